/* sv/agglomerative_box_clustering_macros.svh */
// Assertion macros for the clustering sequencer.
`ifndef AGGLOMERATIVE_BOX_CLUSTERING_MACROS_SVH
`define AGGLOMERATIVE_BOX_CLUSTERING_MACROS_SVH

// same-cycle implication
`define ABC_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ABC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/abc_pkg.sv */
// Shared constants, types and datapath command/status/record structs.
package abc_pkg;

    localparam int MAX_CLUSTERS = 32;
    localparam int COORD_BITS   = 16;
    localparam int SLOT_BITS    = $clog2(MAX_CLUSTERS);
    localparam int CNT_BITS     = $clog2(MAX_CLUSTERS + 1);
    localparam int ID_BITS      = 6;
    localparam int CFG_BITS     = 6;
    localparam int AREA_BITS    = 2 * COORD_BITS + 2;

    typedef logic [COORD_BITS-1:0]      t_coord;
    typedef logic [2:0][COORD_BITS-1:0] t_vec;
    typedef logic [SLOT_BITS-1:0]       t_slot;
    typedef logic [CNT_BITS-1:0]        t_cnt;
    typedef logic [ID_BITS-1:0]         t_id;
    typedef logic [CFG_BITS-1:0]        t_cfg;
    typedef logic [AREA_BITS-1:0]       t_area;

    localparam logic [1:0] WS_IN  = 2'd0;
    localparam logic [1:0] WS_RA  = 2'd1;
    localparam logic [1:0] WS_MRG = 2'd2;

    typedef struct packed {
        logic       iss_v;
        logic       iss_cmp;
        t_slot      iss_a;
        t_slot      iss_b;
        logic       acc_clr;
        t_slot      acc_def;
        logic       wr_en;
        logic [1:0] wr_sel;
        t_slot      wr_addr;
        t_id        wr_id;
        logic       np_we;
        t_slot      np_wa;
        t_slot      np_wd;
        t_slot      np_ra;
        logic       mrg_cap;
        logic       out_ld_mrg;
        logic       out_ld_root;
        t_id        out_id;
        logic       out_final;
    } t_dp_cmd;

    typedef struct packed {
        logic  pipe_busy;
        logic  out_busy;
        t_slot best_a;
        t_slot best_b;
        t_slot near_rd;
    } t_dp_sts;

    typedef struct packed {
        logic kind;
        t_id  node_id;
        t_id  left_id;
        t_id  right_id;
        t_vec lo;
        t_vec hi;
        logic fin;
    } t_rec;

endpackage

/* sv/abc_box_if.sv */
// Input channel carrying one box per beat.
interface abc_box_if;
    logic                                    valid;
    logic                                    ready;
    logic signed [abc_pkg::COORD_BITS-1:0]   min_x;
    logic signed [abc_pkg::COORD_BITS-1:0]   min_y;
    logic signed [abc_pkg::COORD_BITS-1:0]   min_z;
    logic signed [abc_pkg::COORD_BITS-1:0]   max_x;
    logic signed [abc_pkg::COORD_BITS-1:0]   max_y;
    logic signed [abc_pkg::COORD_BITS-1:0]   max_z;
    logic                                    last_box;

    modport source (output valid, min_x, min_y, min_z, max_x, max_y, max_z, last_box,
                    input ready);
    modport sink   (input valid, min_x, min_y, min_z, max_x, max_y, max_z, last_box,
                    output ready);
endinterface

/* sv/abc_rec_if.sv */
// Output channel carrying one merge or root record per beat.
interface abc_rec_if;
    logic                                    valid;
    logic                                    ready;
    logic                                    record_kind;
    logic [abc_pkg::ID_BITS-1:0]             node_id;
    logic [abc_pkg::ID_BITS-1:0]             left_id;
    logic [abc_pkg::ID_BITS-1:0]             right_id;
    logic signed [abc_pkg::COORD_BITS-1:0]   out_min_x;
    logic signed [abc_pkg::COORD_BITS-1:0]   out_min_y;
    logic signed [abc_pkg::COORD_BITS-1:0]   out_min_z;
    logic signed [abc_pkg::COORD_BITS-1:0]   out_max_x;
    logic signed [abc_pkg::COORD_BITS-1:0]   out_max_y;
    logic signed [abc_pkg::COORD_BITS-1:0]   out_max_z;
    logic                                    final_record;

    modport source (output valid, record_kind, node_id, left_id, right_id, out_min_x,
                    out_min_y, out_min_z, out_max_x, out_max_y, out_max_z, final_record,
                    input ready);
    modport sink   (input valid, record_kind, node_id, left_id, right_id, out_min_x,
                    out_min_y, out_min_z, out_max_x, out_max_y, out_max_z, final_record,
                    output ready);
endinterface

/* sv/abc_datapath.sv */
// Slot memories, partner table, union-area pipeline, best-pair tracker, record register.
module abc_datapath (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  abc_pkg::t_dp_cmd i_cmd,
    input  abc_pkg::t_vec    i_in_lo,
    input  abc_pkg::t_vec    i_in_hi,
    input  logic             i_out_ready,
    output abc_pkg::t_dp_sts o_sts,
    output abc_pkg::t_rec    o_rec,
    output logic             o_rec_valid
);
    abc_pkg::t_vec  m_lo [abc_pkg::MAX_CLUSTERS];
    abc_pkg::t_vec  m_hi [abc_pkg::MAX_CLUSTERS];
    abc_pkg::t_id   m_id [abc_pkg::MAX_CLUSTERS];
    abc_pkg::t_slot r_np [abc_pkg::MAX_CLUSTERS];

    abc_pkg::t_vec  n_wr_lo, n_wr_hi;
    abc_pkg::t_id   n_wr_id;

    abc_pkg::t_vec  r_a_lo, r_a_hi, r_b_lo, r_b_hi;
    abc_pkg::t_id   r_a_id, r_b_id;
    abc_pkg::t_vec  n_u_lo, n_u_hi, r_u_lo, r_u_hi;
    abc_pkg::t_id   r_u_aid, r_u_bid;
    abc_pkg::t_vec  n_ext, r_ext;
    logic [2*abc_pkg::COORD_BITS-1:0] r_p0, r_p1, r_p2;
    abc_pkg::t_area r_sum;
    abc_pkg::t_slot r_a1, r_b1, r_a2, r_b2, r_a3, r_b3, r_a4, r_b4, r_a5, r_b5;
    logic           r_v1, r_v2, r_v3, r_v4, r_v5;

    logic           r_found;
    abc_pkg::t_area r_best_d;
    abc_pkg::t_slot r_best_a, r_best_b;

    abc_pkg::t_vec  r_m_lo, r_m_hi;
    abc_pkg::t_id   r_m_aid, r_m_bid;
    abc_pkg::t_rec  r_out;
    logic           r_out_v;

    always_comb begin
        case (i_cmd.wr_sel)
            abc_pkg::WS_IN: begin
                n_wr_lo = i_in_lo;
                n_wr_hi = i_in_hi;
                n_wr_id = i_cmd.wr_id;
            end
            abc_pkg::WS_RA: begin
                n_wr_lo = r_a_lo;
                n_wr_hi = r_a_hi;
                n_wr_id = r_a_id;
            end
            default: begin
                n_wr_lo = r_m_lo;
                n_wr_hi = r_m_hi;
                n_wr_id = i_cmd.wr_id;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            m_lo[i_cmd.wr_addr] <= n_wr_lo;
            m_hi[i_cmd.wr_addr] <= n_wr_hi;
            m_id[i_cmd.wr_addr] <= n_wr_id;
        end
        r_a_lo <= m_lo[i_cmd.iss_a];
        r_a_hi <= m_hi[i_cmd.iss_a];
        r_a_id <= m_id[i_cmd.iss_a];
        r_b_lo <= m_lo[i_cmd.iss_b];
        r_b_hi <= m_hi[i_cmd.iss_b];
        r_b_id <= m_id[i_cmd.iss_b];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.np_we) begin
            r_np[i_cmd.np_wa] <= i_cmd.np_wd;
        end
    end

    always_comb begin
        logic signed [abc_pkg::COORD_BITS:0] d;
        d = '0;
        for (int k = 0; k < 3; k++) begin
            n_u_lo[k] = ($signed(r_a_lo[k]) < $signed(r_b_lo[k])) ? r_a_lo[k] : r_b_lo[k];
            n_u_hi[k] = ($signed(r_a_hi[k]) > $signed(r_b_hi[k])) ? r_a_hi[k] : r_b_hi[k];
        end
        for (int k = 0; k < 3; k++) begin
            d = $signed({r_u_hi[k][abc_pkg::COORD_BITS-1], r_u_hi[k]})
              - $signed({r_u_lo[k][abc_pkg::COORD_BITS-1], r_u_lo[k]});
            n_ext[k] = d[abc_pkg::COORD_BITS] ? '0 : d[abc_pkg::COORD_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_u_lo  <= n_u_lo;
        r_u_hi  <= n_u_hi;
        r_u_aid <= r_a_id;
        r_u_bid <= r_b_id;
        r_ext   <= n_ext;
        r_p0    <= r_ext[0] * r_ext[1];
        r_p1    <= r_ext[0] * r_ext[2];
        r_p2    <= r_ext[1] * r_ext[2];
        r_sum   <= abc_pkg::AREA_BITS'(r_p0) + abc_pkg::AREA_BITS'(r_p1)
                 + abc_pkg::AREA_BITS'(r_p2);
        r_a1 <= i_cmd.iss_a;
        r_b1 <= i_cmd.iss_b;
        r_a2 <= r_a1;
        r_b2 <= r_b1;
        r_a3 <= r_a2;
        r_b3 <= r_b2;
        r_a4 <= r_a3;
        r_b4 <= r_b3;
        r_a5 <= r_a4;
        r_b5 <= r_b4;
        if (i_cmd.mrg_cap) begin
            r_m_lo  <= r_u_lo;
            r_m_hi  <= r_u_hi;
            r_m_aid <= r_u_aid;
            r_m_bid <= r_u_bid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.iss_v & i_cmd.iss_cmp;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (i_cmd.acc_clr) begin
            r_found <= 1'b0;
        end else if (r_v5) begin
            r_found <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.acc_clr) begin
            r_best_a <= i_cmd.acc_def;
            r_best_b <= i_cmd.acc_def;
            r_best_d <= '0;
        end else if (r_v5 && (!r_found || r_sum < r_best_d)) begin
            r_best_a <= r_a5;
            r_best_b <= r_b5;
            r_best_d <= r_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (i_cmd.out_ld_mrg || i_cmd.out_ld_root) begin
            r_out_v <= 1'b1;
        end else if (i_out_ready) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_ld_mrg) begin
            r_out.kind     <= 1'b0;
            r_out.node_id  <= i_cmd.out_id;
            r_out.left_id  <= r_m_aid;
            r_out.right_id <= r_m_bid;
            r_out.lo       <= r_m_lo;
            r_out.hi       <= r_m_hi;
            r_out.fin      <= 1'b0;
        end else if (i_cmd.out_ld_root) begin
            r_out.kind     <= 1'b1;
            r_out.node_id  <= r_a_id;
            r_out.left_id  <= '0;
            r_out.right_id <= '0;
            r_out.lo       <= r_a_lo;
            r_out.hi       <= r_a_hi;
            r_out.fin      <= i_cmd.out_final;
        end
    end

    assign o_sts.pipe_busy = r_v1 | r_v2 | r_v3 | r_v4 | r_v5;
    assign o_sts.out_busy  = r_out_v;
    assign o_sts.best_a    = r_best_a;
    assign o_sts.best_b    = r_best_b;
    assign o_sts.near_rd   = r_np[i_cmd.np_ra];
    assign o_rec           = r_out;
    assign o_rec_valid     = r_out_v;

endmodule

/* sv/abc_ctrl.sv */
// Sequencer for loading, partner scans, merges, fix-ups and root readout.
`include "agglomerative_box_clustering_macros.svh"

module abc_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  abc_pkg::t_cfg    i_cfg_data,
    input  logic             i_in_valid,
    input  logic             i_in_last,
    output logic             o_in_ready,
    output abc_pkg::t_dp_cmd o_cmd,
    input  abc_pkg::t_dp_sts i_sts
);
    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_PS_ISS  = 4'd1;
    localparam logic [3:0] S_PS_WAIT = 4'd2;
    localparam logic [3:0] S_CHK     = 4'd3;
    localparam logic [3:0] S_GS_ISS  = 4'd4;
    localparam logic [3:0] S_GS_WAIT = 4'd5;
    localparam logic [3:0] S_MG_ISS  = 4'd6;
    localparam logic [3:0] S_MG_W1   = 4'd7;
    localparam logic [3:0] S_MG_CAP  = 4'd8;
    localparam logic [3:0] S_MG_OUT  = 4'd9;
    localparam logic [3:0] S_CP_RD   = 4'd10;
    localparam logic [3:0] S_CP_WR   = 4'd11;
    localparam logic [3:0] S_WT      = 4'd12;
    localparam logic [3:0] S_FX      = 4'd13;
    localparam logic [3:0] S_RT_ISS  = 4'd14;
    localparam logic [3:0] S_RT_OUT  = 4'd15;

    localparam logic [1:0] RET_INIT = 2'd0;
    localparam logic [1:0] RET_T    = 2'd1;
    localparam logic [1:0] RET_FIX  = 2'd2;

    logic [3:0]     r_state, n_state;
    abc_pkg::t_cnt  r_cnt, n_cnt;
    abc_pkg::t_id   r_next, n_next;
    abc_pkg::t_cfg  r_target;
    abc_pkg::t_slot r_i, n_i, r_j, n_j, r_l, n_l, r_r, n_r;
    logic [1:0]     r_ret, n_ret;

    abc_pkg::t_cnt  w_cnt_m1;
    abc_pkg::t_slot w_last;
    abc_pkg::t_cfg  w_tgt;
    abc_pkg::t_slot w_t;

    assign w_cnt_m1 = r_cnt - abc_pkg::CNT_BITS'(1);
    assign w_last   = w_cnt_m1[abc_pkg::SLOT_BITS-1:0];
    assign w_tgt    = (r_target == '0) ? abc_pkg::CFG_BITS'(1) : r_target;
    assign w_t      = (r_l != w_last) ? r_l : r_r;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= abc_pkg::CFG_BITS'(1);
        end else if (i_cfg_we) begin
            r_target <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_next  <= '0;
            r_i     <= '0;
            r_j     <= '0;
            r_l     <= '0;
            r_r     <= '0;
            r_ret   <= RET_INIT;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_next  <= n_next;
            r_i     <= n_i;
            r_j     <= n_j;
            r_l     <= n_l;
            r_r     <= n_r;
            r_ret   <= n_ret;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_next     = r_next;
        n_i        = r_i;
        n_j        = r_j;
        n_l        = r_l;
        n_r        = r_r;
        n_ret      = r_ret;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.wr_sel = abc_pkg::WS_IN;

        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (int'(r_cnt) < abc_pkg::MAX_CLUSTERS) begin
                        o_cmd.wr_en   = 1'b1;
                        o_cmd.wr_sel  = abc_pkg::WS_IN;
                        o_cmd.wr_addr = r_cnt[abc_pkg::SLOT_BITS-1:0];
                        o_cmd.wr_id   = r_next;
                        n_cnt         = r_cnt + abc_pkg::CNT_BITS'(1);
                        n_next        = r_next + abc_pkg::ID_BITS'(1);
                    end
                    if (i_in_last) begin
                        n_state = S_PS_ISS;
                        n_i     = '0;
                        n_j     = '0;
                        n_ret   = RET_INIT;
                    end
                end
            end
            S_PS_ISS: begin
                o_cmd.acc_clr = (r_j == '0);
                o_cmd.acc_def = r_i;
                o_cmd.iss_v   = (r_j != r_i);
                o_cmd.iss_cmp = 1'b1;
                o_cmd.iss_a   = r_i;
                o_cmd.iss_b   = r_j;
                if (r_j == w_last) begin
                    n_state = S_PS_WAIT;
                end else begin
                    n_j = r_j + abc_pkg::SLOT_BITS'(1);
                end
            end
            S_PS_WAIT: begin
                if (!i_sts.pipe_busy) begin
                    o_cmd.np_we = 1'b1;
                    o_cmd.np_wa = r_i;
                    o_cmd.np_wd = i_sts.best_b;
                    n_j         = '0;
                    case (r_ret)
                        RET_INIT: begin
                            if (r_i == w_last) begin
                                n_state = S_CHK;
                            end else begin
                                n_i     = r_i + abc_pkg::SLOT_BITS'(1);
                                n_state = S_PS_ISS;
                            end
                        end
                        RET_T: begin
                            n_i     = '0;
                            n_state = S_FX;
                        end
                        default: begin
                            if (r_i == w_last) begin
                                n_state = S_CHK;
                            end else begin
                                n_i     = r_i + abc_pkg::SLOT_BITS'(1);
                                n_state = S_FX;
                            end
                        end
                    endcase
                end
            end
            S_CHK: begin
                n_i = '0;
                if (int'(r_cnt) > int'(w_tgt)) begin
                    n_state = S_GS_ISS;
                end else begin
                    n_state = S_RT_ISS;
                end
            end
            S_GS_ISS: begin
                o_cmd.np_ra   = r_i;
                o_cmd.acc_clr = (r_i == '0);
                o_cmd.iss_v   = 1'b1;
                o_cmd.iss_cmp = 1'b1;
                o_cmd.iss_a   = r_i;
                o_cmd.iss_b   = i_sts.near_rd;
                if (r_i == w_last) begin
                    n_state = S_GS_WAIT;
                end else begin
                    n_i = r_i + abc_pkg::SLOT_BITS'(1);
                end
            end
            S_GS_WAIT: begin
                if (!i_sts.pipe_busy) begin
                    n_l     = i_sts.best_a;
                    n_r     = i_sts.best_b;
                    n_state = S_MG_ISS;
                end
            end
            S_MG_ISS: begin
                o_cmd.iss_v = 1'b1;
                o_cmd.iss_a = r_l;
                o_cmd.iss_b = r_r;
                n_state     = S_MG_W1;
            end
            S_MG_W1: begin
                n_state = S_MG_CAP;
            end
            S_MG_CAP: begin
                o_cmd.mrg_cap = 1'b1;
                n_state       = S_MG_OUT;
            end
            S_MG_OUT: begin
                if (!i_sts.out_busy) begin
                    o_cmd.out_ld_mrg = 1'b1;
                    o_cmd.out_id     = r_next;
                    n_state          = (r_l != w_last) ? S_CP_RD : S_WT;
                end
            end
            S_CP_RD: begin
                o_cmd.iss_v = 1'b1;
                o_cmd.iss_a = w_last;
                o_cmd.iss_b = w_last;
                n_state     = S_CP_WR;
            end
            S_CP_WR: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_sel  = abc_pkg::WS_RA;
                o_cmd.wr_addr = r_r;
                o_cmd.np_ra   = w_last;
                o_cmd.np_we   = 1'b1;
                o_cmd.np_wa   = r_r;
                o_cmd.np_wd   = i_sts.near_rd;
                n_state       = S_WT;
            end
            S_WT: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_sel  = abc_pkg::WS_MRG;
                o_cmd.wr_addr = w_t;
                o_cmd.wr_id   = r_next;
                n_next        = r_next + abc_pkg::ID_BITS'(1);
                n_cnt         = w_cnt_m1;
                n_i           = w_t;
                n_j           = '0;
                n_ret         = RET_T;
                n_state       = S_PS_ISS;
            end
            S_FX: begin
                o_cmd.np_ra = r_i;
                if (i_sts.near_rd == r_l || i_sts.near_rd == r_r) begin
                    n_j     = '0;
                    n_ret   = RET_FIX;
                    n_state = S_PS_ISS;
                end else begin
                    if (abc_pkg::CNT_BITS'(i_sts.near_rd) == r_cnt) begin
                        o_cmd.np_we = 1'b1;
                        o_cmd.np_wa = r_i;
                        o_cmd.np_wd = r_r;
                    end
                    if (r_i == w_last) begin
                        n_state = S_CHK;
                    end else begin
                        n_i = r_i + abc_pkg::SLOT_BITS'(1);
                    end
                end
            end
            S_RT_ISS: begin
                if (!i_sts.out_busy) begin
                    o_cmd.iss_v = 1'b1;
                    o_cmd.iss_a = r_i;
                    o_cmd.iss_b = r_i;
                    n_state     = S_RT_OUT;
                end
            end
            S_RT_OUT: begin
                o_cmd.out_ld_root = 1'b1;
                o_cmd.out_final   = (r_i == w_last);
                if (r_i == w_last) begin
                    n_cnt   = '0;
                    n_next  = '0;
                    n_state = S_IDLE;
                end else begin
                    n_i     = r_i + abc_pkg::SLOT_BITS'(1);
                    n_state = S_RT_ISS;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    `ABC_ASSERT_NOW(a_cnt_range, i_clk, i_rst_n, 1'b1, int'(r_cnt) <= abc_pkg::MAX_CLUSTERS, "live count beyond slot store")
    `ABC_ASSERT_NOW(a_iss_in_range, i_clk, i_rst_n, o_cmd.iss_v && r_state != S_IDLE, r_cnt != '0 && int'(o_cmd.iss_a) < int'(r_cnt) && int'(o_cmd.iss_b) < int'(r_cnt), "slot read outside live clusters")
    `ABC_ASSERT_NOW(a_np_in_range, i_clk, i_rst_n, o_cmd.np_we, int'(o_cmd.np_wd) < int'(r_cnt), "partner points outside live clusters")
    `ABC_ASSERT_NOW(a_no_overwrite, i_clk, i_rst_n, o_cmd.out_ld_mrg || o_cmd.out_ld_root, !i_sts.out_busy, "record loaded over pending beat")
    `ABC_ASSERT_NEXT(a_done_clears, i_clk, i_rst_n, r_state == S_RT_OUT && r_i == w_last, r_cnt == '0 && r_state == S_IDLE, "set not cleared after final root")

endmodule

/* sv/agglomerative_box_clustering.sv */
// Top level: agglomerative clustering of axis-aligned boxes by union surface area.
//
//  channel   | dir | beat contents
//  ----------+-----+--------------------------------------------------------------
//  i_box     | in  | min/max corner of one box, last_box flag closing the set
//  o_rec     | out | merge or root record: ids, union box, final_record flag
//  i_cfg_*   | in  | target_clusters write, no read-back
//
// Loading accepts one box per cycle. Each partner scan streams the live clusters
// through the single union-area pipeline; after the last box, the initial scan runs
// one partner scan per live cluster. Each merge takes a global pick over all live
// clusters, the merge and slot move, one rescan of the merged cluster, a fix-up check
// per live cluster and one rescan per fixed-up partner. A stalled o_rec holds the
// sequencer only when the next record is ready. Synchronous active-low reset.
module agglomerative_box_clustering (
    input  logic          i_clk,
    input  logic          i_rst_n,
    abc_box_if.sink       i_box,
    abc_rec_if.source     o_rec,
    input  logic          i_cfg_we,
    input  abc_pkg::t_cfg i_cfg_data
);
    abc_pkg::t_dp_cmd w_cmd;
    abc_pkg::t_dp_sts w_sts;
    abc_pkg::t_vec    w_in_lo, w_in_hi;
    abc_pkg::t_rec    w_rec;

    assign w_in_lo[0] = i_box.min_x;
    assign w_in_lo[1] = i_box.min_y;
    assign w_in_lo[2] = i_box.min_z;
    assign w_in_hi[0] = i_box.max_x;
    assign w_in_hi[1] = i_box.max_y;
    assign w_in_hi[2] = i_box.max_z;

    abc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_box.valid),
        .i_in_last  (i_box.last_box),
        .o_in_ready (i_box.ready),
        .o_cmd      (w_cmd),
        .i_sts      (w_sts)
    );

    abc_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_in_lo     (w_in_lo),
        .i_in_hi     (w_in_hi),
        .i_out_ready (o_rec.ready),
        .o_sts       (w_sts),
        .o_rec       (w_rec),
        .o_rec_valid (o_rec.valid)
    );

    assign o_rec.record_kind  = w_rec.kind;
    assign o_rec.node_id      = w_rec.node_id;
    assign o_rec.left_id      = w_rec.left_id;
    assign o_rec.right_id     = w_rec.right_id;
    assign o_rec.out_min_x    = w_rec.lo[0];
    assign o_rec.out_min_y    = w_rec.lo[1];
    assign o_rec.out_min_z    = w_rec.lo[2];
    assign o_rec.out_max_x    = w_rec.hi[0];
    assign o_rec.out_max_y    = w_rec.hi[1];
    assign o_rec.out_max_z    = w_rec.hi[2];
    assign o_rec.final_record = w_rec.fin;

endmodule

/* tb/testbench.sv */
// Testbench for agglomerative_box_clustering: directed and random box sets checked against a predictor.
module testbench;

    typedef struct {
        bit        kind;
        bit [5:0]  node;
        bit [5:0]  left;
        bit [5:0]  right;
        bit [15:0] lo [3];
        bit [15:0] hi [3];
        bit        fin;
    } t_cluster_rec;

    typedef struct {
        int lo [3];
        int hi [3];
    } t_box;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    abc_pkg::t_cfg i_cfg_data;

    abc_box_if box_ch ();
    abc_rec_if rec_ch ();

    agglomerative_box_clustering dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_box      (box_ch.sink),
        .o_rec      (rec_ch.source),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    int slot_lo [abc_pkg::MAX_CLUSTERS][3];
    int slot_hi [abc_pkg::MAX_CLUSTERS][3];
    int slot_node [abc_pkg::MAX_CLUSTERS];
    int partner [abc_pkg::MAX_CLUSTERS];
    int live_boxes;
    int next_node;
    int target_reg;

    t_cluster_rec pending_recs [$];
    int  mismatches;
    int  box_count;
    bit  send_no_gaps;
    bit  recv_no_stalls;

    always #10 i_clk = ~i_clk;

    function automatic longint union_area(int a, int b);
        longint e [3];
        int     l;
        int     h;
        for (int k = 0; k < 3; k++) begin
            l = slot_lo[a][k] < slot_lo[b][k] ? slot_lo[a][k] : slot_lo[b][k];
            h = slot_hi[a][k] > slot_hi[b][k] ? slot_hi[a][k] : slot_hi[b][k];
            e[k] = h >= l ? longint'(h) - longint'(l) : 0;
        end
        return 2 * (e[0] * e[1] + e[0] * e[2] + e[1] * e[2]);
    endfunction

    function automatic int nearest_slot(int i, int c);
        int     idx;
        bit     found;
        longint bd;
        longint d;
        idx   = i;
        found = 0;
        bd    = 0;
        for (int j = 0; j < c; j++) begin
            if (j != i) begin
                d = union_area(i, j);
                if (!found || d < bd) begin
                    found = 1;
                    bd    = d;
                    idx   = j;
                end
            end
        end
        return idx;
    endfunction

    task automatic push_rec(bit kind, int id, int l, int r, int lo [3], int hi [3]);
        t_cluster_rec rec;
        rec.kind  = kind;
        rec.node  = id[5:0];
        rec.left  = l[5:0];
        rec.right = r[5:0];
        for (int k = 0; k < 3; k++) begin
            rec.lo[k] = lo[k][15:0];
            rec.hi[k] = hi[k][15:0];
        end
        rec.fin = 0;
        pending_recs.push_back(rec);
    endtask

    task automatic cluster_set();
        int     c;
        int     tgt;
        int     lsl;
        int     rsl;
        int     last;
        int     tsl;
        int     id;
        int     p;
        int     lo [3];
        int     hi [3];
        longint bd;
        longint d;
        bit     found;
        c   = live_boxes;
        tgt = target_reg == 0 ? 1 : target_reg;
        for (int i = 0; i < c; i++) partner[i] = nearest_slot(i, c);
        while (c > tgt) begin
            lsl   = 0;
            rsl   = 0;
            last  = c - 1;
            found = 0;
            bd    = 0;
            for (int i = 0; i < c; i++) begin
                p = partner[i];
                if (p >= abc_pkg::MAX_CLUSTERS) p = i;
                d = union_area(i, p);
                if (!found || d < bd) begin
                    found = 1;
                    bd    = d;
                    lsl   = i;
                    rsl   = p;
                end
            end
            for (int k = 0; k < 3; k++) begin
                lo[k] = slot_lo[lsl][k] < slot_lo[rsl][k] ? slot_lo[lsl][k] : slot_lo[rsl][k];
                hi[k] = slot_hi[lsl][k] > slot_hi[rsl][k] ? slot_hi[lsl][k] : slot_hi[rsl][k];
            end
            id        = next_node;
            next_node = (next_node + 1) % 64;
            push_rec(0, id, slot_node[lsl], slot_node[rsl], lo, hi);
            if (lsl != last) begin
                tsl = lsl;
                slot_lo[rsl]   = slot_lo[last];
                slot_hi[rsl]   = slot_hi[last];
                slot_node[rsl] = slot_node[last];
                partner[rsl]   = partner[last];
            end else begin
                tsl = rsl;
            end
            slot_lo[tsl]   = lo;
            slot_hi[tsl]   = hi;
            slot_node[tsl] = id;
            c--;
            partner[tsl] = nearest_slot(tsl, c);
            for (int i = 0; i < c; i++) begin
                if (partner[i] == lsl || partner[i] == rsl) begin
                    partner[i] = nearest_slot(i, c);
                end else if (partner[i] == c) begin
                    partner[i] = rsl;
                end
            end
        end
        for (int i = 0; i < c; i++) push_rec(1, slot_node[i], 0, 0, slot_lo[i], slot_hi[i]);
        if (pending_recs.size() > 0) pending_recs[pending_recs.size() - 1].fin = 1;
        live_boxes = 0;
        next_node  = 0;
    endtask

    task automatic predict_box(t_box b, bit last);
        if (live_boxes < abc_pkg::MAX_CLUSTERS) begin
            slot_lo[live_boxes]   = b.lo;
            slot_hi[live_boxes]   = b.hi;
            slot_node[live_boxes] = next_node;
            next_node  = (next_node + 1) % 64;
            live_boxes++;
        end
        if (last) cluster_set();
    endtask

    task automatic send_box(t_box b, bit last);
        int gap;
        gap = send_no_gaps ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            box_ch.valid = 0;
            repeat (gap) @(negedge i_clk);
        end
        box_ch.valid    = 1;
        box_ch.min_x    = b.lo[0];
        box_ch.min_y    = b.lo[1];
        box_ch.min_z    = b.lo[2];
        box_ch.max_x    = b.hi[0];
        box_ch.max_y    = b.hi[1];
        box_ch.max_z    = b.hi[2];
        box_ch.last_box = last;
        do @(posedge i_clk); while (!box_ch.ready);
        predict_box(b, last);
        box_count++;
        @(negedge i_clk);
    endtask

    task automatic drain();
        int guard;
        box_ch.valid = 0;
        guard = 0;
        while (pending_recs.size() > 0 && guard < 200000) begin
            @(negedge i_clk);
            guard++;
        end
        repeat (40) @(negedge i_clk);
    endtask

    task automatic set_target(int v);
        drain();
        i_cfg_we   = 1;
        i_cfg_data = v[5:0];
        @(negedge i_clk);
        i_cfg_we   = 0;
        target_reg = v & 63;
    endtask

    function automatic t_box make_box(int lx, int ly, int lz, int hx, int hy, int hz);
        t_box b;
        b.lo[0] = lx;
        b.lo[1] = ly;
        b.lo[2] = lz;
        b.hi[0] = hx;
        b.hi[1] = hy;
        b.hi[2] = hz;
        return b;
    endfunction

    function automatic t_box random_box(int mode);
        t_box b;
        int   s;
        for (int k = 0; k < 3; k++) begin
            case (mode)
                0: begin
                    b.lo[k] = $urandom_range(0, 3);
                    b.hi[k] = b.lo[k] + $urandom_range(0, 2);
                end
                1: begin
                    b.lo[k] = $signed(16'($urandom));
                    b.hi[k] = $signed(16'($urandom));
                end
                default: begin
                    s = $urandom_range(0, 2000);
                    b.lo[k] = $signed(16'($urandom_range(0, 60000) - 30000));
                    b.hi[k] = b.lo[k] + s > 32767 ? 32767 : b.lo[k] + s;
                end
            endcase
        end
        return b;
    endfunction

    task automatic send_set(int n, int mode);
        for (int i = 0; i < n; i++) send_box(random_box(mode), i == n - 1);
    endtask

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    initial begin
        t_cluster_rec want;
        int stall;
        rec_ch.ready = 0;
        @(negedge i_clk);
        forever begin
            stall = recv_no_stalls ? 0 : $urandom_range(0, 4);
            if (stall > 0) begin
                rec_ch.ready = 0;
                repeat (stall) @(negedge i_clk);
            end
            rec_ch.ready = 1;
            do @(posedge i_clk); while (!rec_ch.valid);
            if (pending_recs.size() == 0) begin
                report_mismatch("unexpected record, node", rec_ch.node_id, -1);
            end else begin
                want = pending_recs.pop_front();
                if (rec_ch.record_kind !== want.kind)
                    report_mismatch("record_kind", rec_ch.record_kind, want.kind);
                if (rec_ch.node_id !== want.node)
                    report_mismatch("node_id", rec_ch.node_id, want.node);
                if (rec_ch.left_id !== want.left)
                    report_mismatch("left_id", rec_ch.left_id, want.left);
                if (rec_ch.right_id !== want.right)
                    report_mismatch("right_id", rec_ch.right_id, want.right);
                if (rec_ch.out_min_x !== want.lo[0])
                    report_mismatch("out_min_x", rec_ch.out_min_x, $signed(want.lo[0]));
                if (rec_ch.out_min_y !== want.lo[1])
                    report_mismatch("out_min_y", rec_ch.out_min_y, $signed(want.lo[1]));
                if (rec_ch.out_min_z !== want.lo[2])
                    report_mismatch("out_min_z", rec_ch.out_min_z, $signed(want.lo[2]));
                if (rec_ch.out_max_x !== want.hi[0])
                    report_mismatch("out_max_x", rec_ch.out_max_x, $signed(want.hi[0]));
                if (rec_ch.out_max_y !== want.hi[1])
                    report_mismatch("out_max_y", rec_ch.out_max_y, $signed(want.hi[1]));
                if (rec_ch.out_max_z !== want.hi[2])
                    report_mismatch("out_max_z", rec_ch.out_max_z, $signed(want.hi[2]));
                if (rec_ch.final_record !== want.fin)
                    report_mismatch("final_record", rec_ch.final_record, want.fin);
            end
            @(negedge i_clk);
        end
    end

    task automatic test_extremes();
        send_box(make_box(-32768, -32768, -32768, 32767, 32767, 32767), 0);
        send_box(make_box(32767, 32767, 32767, 32767, 32767, 32767), 0);
        send_box(make_box(100, -5, 7, -100, 5, -7), 0);
        send_box(make_box(-32768, 0, 32767, -32768, 0, 32767), 1);
        send_box(make_box(1, 2, 3, 4, 5, 6), 1);
        for (int i = 0; i < 4; i++) send_box(make_box(0, 0, 0, 1, 1, 1), i == 3);
        send_box(make_box(0, 0, 0, 1, 1, 1), 0);
        send_box(make_box(5, 0, 0, 6, 1, 1), 0);
        send_box(make_box(-5, 0, 0, -4, 1, 1), 1);
    endtask

    task automatic test_targets();
        set_target(0);
        send_set(3, 2);
        set_target(32);
        send_set(5, 2);
        set_target(63);
        send_set(4, 0);
        set_target(2);
        send_set(6, 0);
        set_target(1);
    endtask

    task automatic test_full_store();
        set_target(32);
        send_set(33, 2);
        set_target(1);
        send_set(34, 1);
        drain();
    endtask

    task automatic test_random();
        int start;
        int n;
        int r;
        start = box_count;
        while (box_count - start < 70) begin
            r = $urandom_range(0, 9);
            send_no_gaps   = r == 0;
            recv_no_stalls = r == 1;
            if (r < 3) set_target($urandom_range(0, 3) == 0 ? $urandom_range(0, 63)
                                                            : $urandom_range(1, 4));
            n = $urandom_range(0, 11) == 0 ? $urandom_range(9, 32) : $urandom_range(1, 8);
            send_set(n, $urandom_range(0, 2));
            if (r == 4) drain();
        end
        send_no_gaps   = 0;
        recv_no_stalls = 0;
    endtask

    initial begin
        i_clk          = 0;
        i_rst_n        = 0;
        i_cfg_we       = 0;
        i_cfg_data     = '0;
        box_ch.valid    = 0;
        box_ch.min_x    = '0;
        box_ch.min_y    = '0;
        box_ch.min_z    = '0;
        box_ch.max_x    = '0;
        box_ch.max_y    = '0;
        box_ch.max_z    = '0;
        box_ch.last_box = 0;
        mismatches     = 0;
        box_count      = 0;
        send_no_gaps   = 0;
        recv_no_stalls = 0;
        live_boxes     = 0;
        next_node      = 0;
        target_reg     = 1;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1;
        test_extremes();
        test_targets();
        test_full_store();
        test_random();
        drain();
        if (mismatches == 0 && pending_recs.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #60000000;
        $display("CHECKS FAILED");
        $finish;
    end
endmodule
